// File: design/lrt_pkg.sv
package lrt_pkg;

  // Input item kinds carried on s_tuser
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_TRAIN = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Result status codes carried on m_tuser
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SAT   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_RATE      = 2'd0;
  localparam logic [1:0] REG_EPOCHS    = 2'd1;
  localparam logic [1:0] REG_SLOPE     = 2'd2;
  localparam logic [1:0] REG_INTERCEPT = 2'd3;

  // Sigmoid breakpoints and offsets, Q16
  localparam logic [37:0] SIG_LIMIT = 38'd327680;
  localparam logic [37:0] SIG_MID   = 38'd155648;
  localparam logic [37:0] SIG_ONE   = 38'd65536;
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] OFS_HIGH  = 17'd55296;
  localparam logic [16:0] OFS_MID   = 17'd40960;
  localparam logic [16:0] OFS_LOW   = 17'd32768;

  // Quotient width of the average divider
  localparam int SUM_W = 48;

endpackage

// File: design/logistic_regression_trainer.sv
// Single-feature logistic regression trainer (batch gradient descent).
// Input channel s_*: s_tuser is the command. A load item stores sample_x and
// label in the sample memory (ignored once MAX_SAMPLES are held); a clear item
// empties the store; a train item runs epoch_count passes from the configured
// initial weights and yields one result on m_*. Command 3 is dropped.
// Load, clear and dropped items are taken back to back.
// A train item makes epoch_count passes and then raises m_tvalid. In a pass
// each sample takes five steps and goes through one shared 48x17 multiplier
// twice (slope*x, then error*x), and each of the two weight updates uses a
// 48-bit restoring divider for the average plus start, sign, multiply-by-rate
// and write-back steps. With no samples or zero epochs the sequencer goes
// straight to the finish step.
// The result sits in an output register; loads and clears are still taken
// while it waits for m_tready, but a finished train holds until the previous
// result is taken. The user must write configuration through cfg_we,
// cfg_index, cfg_data only while the block is idle; it does not enforce this.
// Reset (rst, synchronous) empties the store, restores the register defaults
// and drops any pending result. The sample memory itself is not cleared.
module logistic_regression_trainer import lrt_pkg::*; #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [15:0] sample_x, [16] label, zero fill above
  input  logic [1:0]  s_tuser,   // [1:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] slope, [63:32] intercept
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int IDXW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [CNTW-1:0] MAX_CNT = CNTW'(MAX_SAMPLES);

  typedef enum logic [3:0] {
    IDLE, RD, MUL1, SIG, MUL2, ACC, DIV_START, DIV_RUN, DIV_END, MUL3, UPD, FIN
  } state_t;

  state_t state;

  // Configuration
  logic [15:0]        learning_rate;
  logic [15:0]        epoch_count;
  logic signed [31:0] initial_slope;
  logic signed [31:0] initial_intercept;

  // Sample memory
  logic signed [15:0] sample_store [MAX_SAMPLES];
  logic               label_store  [MAX_SAMPLES];
  logic signed [15:0] rd_x;
  logic               rd_label;

  // Training state
  logic [CNTW-1:0]    sample_count;
  logic [IDXW-1:0]    sample_index;
  logic [15:0]        epoch_counter;
  logic signed [31:0] slope_reg;
  logic signed [31:0] intercept_reg;
  logic signed [47:0] slope_error_sum;
  logic signed [47:0] intercept_error_sum;
  logic signed [17:0] err;
  logic               upd_int;
  logic               sat;
  logic [1:0]         status;

  // Shared multiplier
  logic signed [47:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [64:0] mul_p;
  logic signed [64:0] prod;

  // Divider
  logic [SUM_W-1:0]   div_q;
  logic [CNTW-1:0]    div_rem;
  logic [5:0]         div_cnt;
  logic               div_neg;
  logic signed [47:0] avg;
  logic [CNTW:0]      rem_sh;

  // Combinational helpers
  logic               in_acc;
  logic               last_sample;
  logic               last_epoch;
  logic signed [37:0] z;
  logic [37:0]        z_abs;
  logic [16:0]        f_val;
  logic [16:0]        p_val;
  logic signed [17:0] err_next;
  logic signed [48:0] isum_wide;
  logic signed [48:0] ssum_wide;
  logic signed [47:0] sel_sum;
  logic signed [65:0] delta;
  logic signed [65:0] w_wide;
  logic signed [31:0] w_old;
  logic signed [31:0] w_next;
  logic               w_sat;

  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    if (v[48] != v[47]) begin
      return v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    return v[47:0];
  endfunction

  assign s_tready = (state == IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign last_sample = ({{(CNTW - IDXW){1'b0}}, sample_index} + CNTW'(1)) == sample_count;
  assign last_epoch  = (epoch_counter + 16'd1) == epoch_count;

  // Pick multiplier operands by step
  always_comb begin
    unique case (state)
      MUL1: begin
        mul_a = {{16{slope_reg[31]}}, slope_reg};
        mul_b = {rd_x[15], rd_x};
      end
      MUL2: begin
        mul_a = {{30{err[17]}}, err};
        mul_b = {rd_x[15], rd_x};
      end
      default: begin
        mul_a = avg;
        mul_b = {1'b0, learning_rate};
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Logit, sigmoid and error for the current sample
  always_comb begin
    z = {{2{prod[47]}}, prod[47:12]} + {{6{intercept_reg[31]}}, intercept_reg};
    z_abs = z[37] ? 38'(-z) : z;
    if (z_abs >= SIG_LIMIT) begin
      f_val = ONE_Q16;
    end else if (z_abs >= SIG_MID) begin
      f_val = 17'(z_abs >> 5) + OFS_HIGH;
    end else if (z_abs >= SIG_ONE) begin
      f_val = 17'(z_abs >> 3) + OFS_MID;
    end else begin
      f_val = 17'(z_abs >> 2) + OFS_LOW;
    end
    p_val = z[37] ? (ONE_Q16 - f_val) : f_val;
    err_next = rd_label ? $signed({1'b0, ONE_Q16 - p_val}) : -$signed({1'b0, p_val});
  end

  // Error sums, widened before saturation
  assign isum_wide = {intercept_error_sum[47], intercept_error_sum}
                   + {{31{err[17]}}, err};
  assign ssum_wide = {slope_error_sum[47], slope_error_sum} + {{15{prod[33]}}, prod[33:0]};

  // Divider step and weight update
  assign sel_sum = upd_int ? intercept_error_sum : slope_error_sum;
  assign rem_sh  = {div_rem, div_q[SUM_W-1]};
  assign delta   = upd_int ? ($signed({prod[64], prod}) >>> 16)
                           : ($signed({prod[64], prod}) >>> 28);
  assign w_old   = upd_int ? intercept_reg : slope_reg;
  assign w_wide  = {{34{w_old[31]}}, w_old} + delta;
  always_comb begin
    w_sat = (w_wide > 66'sd2147483647) || (w_wide < -66'sd2147483648);
    if (w_wide > 66'sd2147483647) begin
      w_next = 32'sh7FFFFFFF;
    end else if (w_wide < -66'sd2147483648) begin
      w_next = 32'sh80000000;
    end else begin
      w_next = w_wide[31:0];
    end
  end

  // Sample memory: write on load, registered read at the current index
  always_ff @(posedge clk) begin
    if (in_acc && s_tuser == CMD_LOAD && sample_count < MAX_CNT) begin
      sample_store[sample_count[IDXW-1:0]] <= s_tdata[15:0];
      label_store[sample_count[IDXW-1:0]]  <= s_tdata[16];
    end
    rd_x     <= sample_store[sample_index];
    rd_label <= label_store[sample_index];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate     <= 16'd1311;
      epoch_count       <= 16'd500;
      initial_slope     <= '0;
      initial_intercept <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RATE:      learning_rate     <= cfg_data[15:0];
        REG_EPOCHS:    epoch_count       <= cfg_data[15:0];
        REG_SLOPE:     initial_slope     <= cfg_data;
        REG_INTERCEPT: initial_intercept <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= IDLE;
      m_tvalid            <= 1'b0;
      sample_count        <= '0;
      sample_index        <= '0;
      epoch_counter       <= '0;
      div_cnt             <= '0;
      slope_reg           <= '0;
      intercept_reg       <= '0;
      slope_error_sum     <= '0;
      intercept_error_sum <= '0;
    end else begin
      // Drop a taken result unless the finish step replaces it
      if (m_tvalid && m_tready && state != FIN) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_acc) begin
            case (s_tuser)
              CMD_LOAD: begin
                if (sample_count < MAX_CNT) begin
                  sample_count <= sample_count + CNTW'(1);
                end
              end
              CMD_CLEAR: sample_count <= '0;
              CMD_TRAIN: begin
                slope_reg           <= initial_slope;
                intercept_reg       <= initial_intercept;
                slope_error_sum     <= '0;
                intercept_error_sum <= '0;
                sample_index        <= '0;
                epoch_counter       <= '0;
                sat                 <= 1'b0;
                if (sample_count == '0) begin
                  status <= ST_EMPTY;
                  state  <= FIN;
                end else if (epoch_count == 16'd0) begin
                  status <= ST_OK;
                  state  <= FIN;
                end else begin
                  state <= RD;
                end
              end
              default: ;
            endcase
          end
        end
        RD: state <= MUL1;
        MUL1: begin
          prod  <= mul_p;
          state <= SIG;
        end
        SIG: begin
          err   <= err_next;
          state <= MUL2;
        end
        MUL2: begin
          prod  <= mul_p;
          state <= ACC;
        end
        ACC: begin
          intercept_error_sum <= sat48(isum_wide);
          slope_error_sum     <= sat48(ssum_wide);
          if (last_sample) begin
            upd_int <= 1'b0;
            state   <= DIV_START;
          end else begin
            sample_index <= sample_index + IDXW'(1);
            state        <= RD;
          end
        end
        // Start magnitude division of the chosen sum by the sample count
        DIV_START: begin
          div_neg <= sel_sum[47];
          div_q   <= sel_sum[47] ? SUM_W'(-sel_sum) : sel_sum;
          div_rem <= '0;
          div_cnt <= 6'(SUM_W - 1);
          state   <= DIV_RUN;
        end
        DIV_RUN: begin
          if (rem_sh >= {1'b0, sample_count}) begin
            div_rem <= CNTW'(rem_sh - {1'b0, sample_count});
            div_q   <= {div_q[SUM_W-2:0], 1'b1};
          end else begin
            div_rem <= rem_sh[CNTW-1:0];
            div_q   <= {div_q[SUM_W-2:0], 1'b0};
          end
          if (div_cnt == '0) begin
            state <= DIV_END;
          end else begin
            div_cnt <= div_cnt - 6'd1;
          end
        end
        DIV_END: begin
          avg   <= div_neg ? -$signed(div_q) : $signed(div_q);
          state <= MUL3;
        end
        MUL3: begin
          prod  <= mul_p;
          state <= UPD;
        end
        UPD: begin
          if (w_sat) begin
            sat <= 1'b1;
          end
          if (!upd_int) begin
            slope_reg <= w_next;
            upd_int   <= 1'b1;
            state     <= DIV_START;
          end else begin
            intercept_reg <= w_next;
            if (last_epoch) begin
              status <= (sat || w_sat) ? ST_SAT : ST_OK;
              state  <= FIN;
            end else begin
              epoch_counter       <= epoch_counter + 16'd1;
              slope_error_sum     <= '0;
              intercept_error_sum <= '0;
              sample_index        <= '0;
              state               <= RD;
            end
          end
        end
        // Hand the result over once the output register is free
        FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {intercept_reg, slope_reg};
            m_tuser  <= status;
            state    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    sample_count <= MAX_CNT)
    else $error("sample count beyond store depth");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == FIN))
    else $error("result raised outside the finish step");

  a_div_runs_only: assert property (@(posedge clk) disable iff (rst)
    (state == DIV_RUN && div_cnt == '0) |=> state == DIV_END)
    else $error("divider did not end after its last bit");

  a_train_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_acc && s_tuser == CMD_TRAIN) |=> state != IDLE)
    else $error("train item did not start the sequencer");
`endif

endmodule
